FILE: src/water_heater_circulation_controller_unit_defines.svh
// Assertion macros shared by the controller RTL.
`ifndef WATER_HEATER_CIRCULATION_CONTROLLER_UNIT_DEFINES_SVH
`define WATER_HEATER_CIRCULATION_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, needs clk and rst in scope
`define WHCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("whcc assertion failed");

// next-cycle implication, needs clk and rst in scope
`define WHCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("whcc assertion failed");

`endif

FILE: src/whcc_pkg.sv
// Package: types, register indexes and constants of the circulation controller.
`default_nettype none
package whcc_pkg;

  localparam int SLOT_MAX       = 4;
  localparam int SLOT_COUNT_DEF = 4;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TANK_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_BELOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_ABOVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEATER_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_A           = 3'd4;

  typedef logic [16:0] slot_t;

  localparam logic [9:0] TANK_SETPOINT_RST    = 10'd450;
  localparam logic [7:0] HYSTERESIS_BELOW_RST = 8'd40;
  localparam logic [7:0] HYSTERESIS_ABOVE_RST = 8'd10;
  localparam logic [8:0] HEATER_OFFSET_RST    = 9'd100;
  localparam slot_t SLOT_RST [SLOT_MAX] = '{17'd24591, 17'd30597, 17'd51087, 17'd73758};

  // DAC scaling: code = floor(x * 32767 / 1000) = 32x + floor(767x / 1000),
  // the second term by reciprocal 767 * ceil(2^30 / 1000), exact for x <= 800
  localparam logic [9:0]  TARGET_MAX = 10'd600;
  localparam logic [10:0] CODE_KNEE  = 11'd800;
  localparam logic [14:0] CODE_LIMIT = 15'd26213;
  localparam logic [29:0] DAC_RECIP  = 30'd823560114;
  localparam int          DAC_SHIFT  = 30;

  localparam logic [5:0] ELAPSED_MAX = 6'd63;

  typedef struct packed {
    logic [9:0] tank_setpoint;
    logic [7:0] hysteresis_below;
    logic [7:0] hysteresis_above;
    logic [8:0] heater_offset;
  } cfg_t;

  typedef struct packed {
    logic               force_normal;
    logic               minute_tick;
    logic [5:0]         minute_now;
    logic [4:0]         hour_now;
    logic signed [11:0] heater_temp;
    logic signed [11:0] tank_temp;
  } in_item_t;

  typedef struct packed {
    logic [14:0] dac_code;
    logic        dac_write;
    logic        mode_now;
    logic        circulation_pump_on;
    logic        charge_pump_on;
    logic        floor_heating_off;
    logic        heater_enable;
  } out_item_t;

endpackage
`default_nettype wire

FILE: src/water_heater_circulation_controller_unit.sv
// Top level: stream ports, input and result registers, config and control step.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+---------------------------------
//  s_*      | in        | s_tvalid/tready  | s_tdata, one control tick
//  m_*      | out       | m_tvalid/tready  | m_tdata, relay flags and DAC code
//  cfg_*    | in        | cfg_write only   | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled: an item is held in the
// input register, the step logic (hysteresis, slot match, run timer, one DAC
// multiply) feeds the result register, and the result register drives m_tvalid
// and m_tdata.
// Synchronous reset clears both valid flags and the control state and loads the config reset values.
// A stalled output holds its item and one more item waits in the input
// register; the input register keeps taking items while the result register
// is free or being drained.
`default_nettype none
`include "water_heater_circulation_controller_unit_defines.svh"
module water_heater_circulation_controller_unit #(
  parameter int SLOT_COUNT = whcc_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // tank_temp[11:0], heater_temp[23:12], hour_now[28:24], minute_now[34:29],
  // minute_tick[35], force_normal[36], zero fill [39:37]
  input  wire logic [whcc_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // heater_enable[0], floor_heating_off[1], charge_pump_on[2],
  // circulation_pump_on[3], mode_now[4], dac_write[5], dac_code[20:6], zero [23:21]
  output logic      [whcc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                             cfg_write,
  input  wire logic [whcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [whcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import whcc_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  in_item_t  in_item_d;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance;
  cfg_t      cfg;
  slot_t     slots [SLOT_COUNT];

  always_comb begin
    in_item_d.tank_temp    = s_tdata[11:0];
    in_item_d.heater_temp  = s_tdata[23:12];
    in_item_d.hour_now     = s_tdata[28:24];
    in_item_d.minute_now   = s_tdata[34:29];
    in_item_d.minute_tick  = s_tdata[35];
    in_item_d.force_normal = s_tdata[36];
  end

  assign advance  = in_valid_r && (!out_valid_r || m_tready);
  assign s_tready = !in_valid_r || advance;
  assign m_tvalid = out_valid_r;
  assign m_tdata  = {3'b000, out_item_r.dac_code, out_item_r.dac_write, out_item_r.mode_now,
                     out_item_r.circulation_pump_on, out_item_r.charge_pump_on,
                     out_item_r.floor_heating_off, out_item_r.heater_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s_tready) in_valid_r <= s_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (m_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_item_r <= in_item_d;
    if (advance) out_item_r <= result;
  end

  whcc_cfg_regs #(.SLOT_COUNT(SLOT_COUNT)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .slots     (slots)
  );

  whcc_core #(.SLOT_COUNT(SLOT_COUNT)) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .slots   (slots),
    .result  (result)
  );

  `WHCC_ASSERT_NEXT(a_in_kept, in_valid_r && !advance, in_valid_r)
  `WHCC_ASSERT_NEXT(a_out_loaded, advance, out_valid_r)
  `WHCC_ASSERT_IMP(a_flags_agree, out_valid_r, m_tdata[0] == m_tdata[1])

endmodule
`default_nettype wire

FILE: src/whcc_cfg_regs.sv
// Configuration registers with their reset values.
`default_nettype none
module whcc_cfg_regs #(
  parameter int SLOT_COUNT = whcc_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [whcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [whcc_pkg::CFG_DATA_W-1:0] cfg_data,
  output whcc_pkg::cfg_t                       cfg,
  output whcc_pkg::slot_t                      slots [SLOT_COUNT]
);
  import whcc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tank_setpoint    <= TANK_SETPOINT_RST;
      cfg.hysteresis_below <= HYSTERESIS_BELOW_RST;
      cfg.hysteresis_above <= HYSTERESIS_ABOVE_RST;
      cfg.heater_offset    <= HEATER_OFFSET_RST;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] <= SLOT_RST[i];
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TANK_SETPOINT:    cfg.tank_setpoint    <= cfg_data[9:0];
        REG_HYSTERESIS_BELOW: cfg.hysteresis_below <= cfg_data[7:0];
        REG_HYSTERESIS_ABOVE: cfg.hysteresis_above <= cfg_data[7:0];
        REG_HEATER_OFFSET:    cfg.heater_offset    <= cfg_data[8:0];
        default: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (cfg_index == CFG_IDX_W'(int'(REG_SLOT_A) + i)) slots[i] <= cfg_data;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/whcc_dac.sv
// Heater target to clamped DAC code conversion.
`default_nettype none
module whcc_dac (
  input  wire logic [9:0]  target,
  input  wire logic [8:0]  heater_offset,
  output logic      [14:0] code
);
  import whcc_pkg::*;

  logic [9:0]  t;
  logic [10:0] x;
  logic [39:0] prod;
  logic [9:0]  frac_part;

  always_comb begin
    t         = (target > TARGET_MAX) ? TARGET_MAX : target;
    x         = {1'b0, t} + {2'b00, heater_offset};
    prod      = 40'(x[9:0]) * 40'(DAC_RECIP);
    frac_part = prod[DAC_SHIFT +: 10];
    if (x > CODE_KNEE) begin
      code = CODE_LIMIT;
    end else begin
      code = {x[9:0], 5'b00000} + 15'(frac_part);
    end
  end

endmodule
`default_nettype wire

FILE: src/whcc_core.sv
// Per-item control step: heating hysteresis, pumps, schedule and run timer.
`default_nettype none
`include "water_heater_circulation_controller_unit_defines.svh"
module whcc_core #(
  parameter int SLOT_COUNT = whcc_pkg::SLOT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  whcc_pkg::in_item_t item,
  input  whcc_pkg::cfg_t   cfg,
  input  whcc_pkg::slot_t  slots [SLOT_COUNT],
  output whcc_pkg::out_item_t result
);
  import whcc_pkg::*;

  logic        heating_active, charge_pump_state, circulation_pump_state;
  logic        circulation_mode, start_pending;
  logic [5:0]  run_length, run_elapsed;
  logic [9:0]  last_heater_target;
  logic [14:0] last_dac_code;

  logic        heating_active_next, charge_pump_state_next, circulation_pump_state_next;
  logic        circulation_mode_next, start_pending_next;
  logic [5:0]  run_length_next, run_elapsed_next;
  logic [9:0]  last_heater_target_next;
  logic [14:0] last_dac_code_next;

  logic signed [12:0] tank, heater, sp, low, high;
  logic               apply;
  logic               wrote;
  logic [9:0]         target;
  logic [14:0]        new_code;
  logic               hit;
  logic [5:0]         hit_dur;

  whcc_dac u_dac (
    .target        (target),
    .heater_offset (cfg.heater_offset),
    .code          (new_code)
  );

  // first matching slot wins: scan from the top so the lowest index lands last
  always_comb begin
    hit     = 1'b0;
    hit_dur = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slots[i][5:0] != 6'd0 && slots[i][16:12] == item.hour_now &&
          slots[i][11:6] == item.minute_now) begin
        hit     = 1'b1;
        hit_dur = slots[i][5:0];
      end
    end
  end

  always_comb begin
    tank   = 13'(item.tank_temp);
    heater = 13'(item.heater_temp);
    sp     = $signed({3'b000, cfg.tank_setpoint});
    low    = sp - $signed({5'b00000, cfg.hysteresis_below});
    high   = sp + $signed({5'b00000, cfg.hysteresis_above});

    // force-normal is applied before everything else
    circulation_mode_next       = item.force_normal ? 1'b0 : circulation_mode;
    start_pending_next          = item.force_normal ? 1'b0 : start_pending;
    circulation_pump_state_next = item.force_normal ? 1'b0 : circulation_pump_state;
    run_elapsed_next            = item.force_normal ? 6'd0 : run_elapsed;
    run_length_next             = run_length;

    heating_active_next = heating_active;
    apply  = 1'b0;
    target = 10'd0;
    if (tank < low && !heating_active) begin
      heating_active_next = 1'b1;
      apply  = 1'b1;
      target = cfg.tank_setpoint;
    end else if (tank > high && heating_active) begin
      heating_active_next = 1'b0;
      apply  = 1'b1;
    end
    wrote = apply && (target != last_heater_target);
    last_heater_target_next = wrote ? target : last_heater_target;
    last_dac_code_next      = wrote ? new_code : last_dac_code;

    charge_pump_state_next = charge_pump_state;
    if (heating_active_next && heater > sp && !charge_pump_state) begin
      charge_pump_state_next = 1'b1;
    end else if ((!heating_active_next || heater < low) && charge_pump_state) begin
      charge_pump_state_next = 1'b0;
    end

    if (!circulation_mode_next) begin
      if (hit) begin
        run_length_next       = hit_dur;
        circulation_mode_next = 1'b1;
        start_pending_next    = 1'b1;
      end
    end else begin
      if (start_pending_next) begin
        if (tank >= low) begin
          circulation_pump_state_next = 1'b1;
          run_elapsed_next            = 6'd0;
          start_pending_next          = 1'b0;
        end
      end else if (item.minute_tick && run_elapsed_next < ELAPSED_MAX) begin
        run_elapsed_next = run_elapsed_next + 6'd1;
      end
      if (!start_pending_next && run_elapsed_next >= run_length) begin
        circulation_pump_state_next = 1'b0;
        circulation_mode_next       = 1'b0;
      end
    end
  end

  always_comb begin
    result.heater_enable       = heating_active_next;
    result.floor_heating_off   = heating_active_next;
    result.charge_pump_on      = charge_pump_state_next;
    result.circulation_pump_on = circulation_pump_state_next;
    result.mode_now            = circulation_mode_next;
    result.dac_write           = wrote;
    result.dac_code            = last_dac_code_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heating_active         <= 1'b0;
      charge_pump_state      <= 1'b0;
      circulation_pump_state <= 1'b0;
      circulation_mode       <= 1'b0;
      start_pending          <= 1'b0;
      run_length             <= '0;
      run_elapsed            <= '0;
      last_heater_target     <= '0;
      last_dac_code          <= '0;
    end else if (advance) begin
      heating_active         <= heating_active_next;
      charge_pump_state      <= charge_pump_state_next;
      circulation_pump_state <= circulation_pump_state_next;
      circulation_mode       <= circulation_mode_next;
      start_pending          <= start_pending_next;
      run_length             <= run_length_next;
      run_elapsed            <= run_elapsed_next;
      last_heater_target     <= last_heater_target_next;
      last_dac_code          <= last_dac_code_next;
    end
  end

  `WHCC_ASSERT_IMP(a_pump_needs_mode, circulation_pump_state, circulation_mode)
  `WHCC_ASSERT_IMP(a_pending_no_pump, start_pending, circulation_mode && !circulation_pump_state)
  `WHCC_ASSERT_IMP(a_charge_needs_heat, charge_pump_state, heating_active)
  `WHCC_ASSERT_NEXT(a_code_holds, advance && !wrote, $stable(last_dac_code))

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking stream testbench for the water heater circulation controller.
`default_nettype none
module testbench;
  import whcc_pkg::*;

  localparam int SLOTS = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_B = REG_SLOT_A + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_C = REG_SLOT_A + 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_D = REG_SLOT_A + 3'd3;
  localparam int unsigned FULL_SCALE = 32767;
  localparam int unsigned CODE_CAP   = 26213;
  localparam int unsigned TARGET_CAP = 600;
  localparam int unsigned TIMER_CAP  = 63;
  localparam int HOLD_CYCLES = 100;

  class heater_ctl_scoreboard;
    logic [9:0] setpoint;
    logic [7:0] hyst_lo, hyst_hi;
    logic [8:0] offset;
    slot_t      slot_cfg [SLOTS];
    logic       heating, charge_on, circ_on, circ_mode, waiting_warm;
    logic [5:0] run_len, run_min;
    logic [9:0] last_target;
    logic [14:0] last_code;
    out_item_t  due_outputs [$];
    int errors, n_ticks, n_results, n_writes, n_runs;

    function new();
      setpoint = 10'd450; hyst_lo = 8'd40; hyst_hi = 8'd10; offset = 9'd100;
      slot_cfg = '{17'd24591, 17'd30597, 17'd51087, 17'd73758};
      heating = 0; charge_on = 0; circ_on = 0; circ_mode = 0; waiting_warm = 0;
      run_len = '0; run_min = '0; last_target = '0; last_code = '0;
      errors = 0; n_ticks = 0; n_results = 0; n_writes = 0; n_runs = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TANK_SETPOINT:    setpoint = data[9:0];
        REG_HYSTERESIS_BELOW: hyst_lo = data[7:0];
        REG_HYSTERESIS_ABOVE: hyst_hi = data[7:0];
        REG_HEATER_OFFSET:    offset = data[8:0];
        REG_SLOT_A, REG_SLOT_B, REG_SLOT_C, REG_SLOT_D: slot_cfg[idx - REG_SLOT_A] = data;
        default: ;
      endcase
    endfunction

    function void note_tick(in_item_t it);
      int tank, heater, sp, lo, hi;
      int unsigned tgt, t, code;
      bit changed, wrote, matched;
      out_item_t o;
      tank = it.tank_temp;
      heater = it.heater_temp;
      sp = int'(setpoint);
      lo = sp - int'(hyst_lo);
      hi = sp + int'(hyst_hi);
      changed = 0; wrote = 0; matched = 0; tgt = 0;
      n_ticks++;
      if (it.force_normal) begin
        circ_mode = 0; waiting_warm = 0; circ_on = 0; run_min = '0;
      end
      if (tank < lo && !heating) begin
        heating = 1; tgt = setpoint; changed = 1;
      end else if (tank > hi && heating) begin
        heating = 0; tgt = 0; changed = 1;
      end
      if (changed && tgt != last_target) begin
        last_target = 10'(tgt);
        t = (tgt > TARGET_CAP) ? TARGET_CAP : tgt;
        code = ((t + offset) * FULL_SCALE) / 1000;
        if (code > CODE_CAP) code = CODE_CAP;
        last_code = 15'(code);
        wrote = 1;
        n_writes++;
      end
      if (heating && heater > sp && !charge_on)
        charge_on = 1;
      else if ((!heating || heater < lo) && charge_on)
        charge_on = 0;
      // mode logic works on the mode as left by force-normal
      if (!circ_mode) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!matched && slot_cfg[i][5:0] != 0 && slot_cfg[i][16:12] == it.hour_now &&
              slot_cfg[i][11:6] == it.minute_now) begin
            run_len = slot_cfg[i][5:0];
            circ_mode = 1;
            waiting_warm = 1;
            matched = 1;
          end
        end
      end else begin
        if (waiting_warm) begin
          if (tank >= lo) begin
            circ_on = 1; run_min = '0; waiting_warm = 0;
            n_runs++;
          end
        end else if (it.minute_tick && run_min < TIMER_CAP) begin
          run_min++;
        end
        if (!waiting_warm && run_min >= run_len) begin
          circ_on = 0; circ_mode = 0;
        end
      end
      o.heater_enable = heating;
      o.floor_heating_off = heating;
      o.charge_pump_on = charge_on;
      o.circulation_pump_on = circ_on;
      o.mode_now = circ_mode;
      o.dac_write = wrote;
      o.dac_code = last_code;
      due_outputs.push_back(o);
    endfunction

    function void check_outputs(out_item_t got);
      out_item_t want;
      if (due_outputs.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, got %h", $time, got);
        return;
      end
      want = due_outputs.pop_front();
      n_results++;
      if (got !== want) begin
        errors++;
        if (errors <= 20) begin
          $display("%0t: expected heat=%0b floor_off=%0b charge=%0b circ=%0b ", $time,
                   want.heater_enable, want.floor_heating_off, want.charge_pump_on,
                   want.circulation_pump_on, "mode=%0b dac_wr=%0b dac=%0d",
                   want.mode_now, want.dac_write, want.dac_code);
          $display("%0t:   actual heat=%0b floor_off=%0b charge=%0b circ=%0b ", $time,
                   got.heater_enable, got.floor_heating_off, got.charge_pump_on,
                   got.circulation_pump_on, "mode=%0b dac_wr=%0b dac=%0d",
                   got.mode_now, got.dac_write, got.dac_code);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  heater_ctl_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int wall_hour = 0;
  int wall_min = 0;
  int tank_walk = 450;
  logic [CFG_DATA_W-1:0] reg_image [8];

  always #10 clk = ~clk;

  water_heater_circulation_controller_unit #(.SLOT_COUNT(SLOTS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_tick(in_item_t'(s_tdata[$bits(in_item_t)-1:0]));
      if (m_tvalid && m_tready) sb.check_outputs(out_item_t'(m_tdata[$bits(out_item_t)-1:0]));
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

  function automatic in_item_t ctl_tick(int tank, int heater, int hour, int minute,
                                        bit tick, bit force_n);
    in_item_t it;
    it.tank_temp = 12'(tank);
    it.heater_temp = 12'(heater);
    it.hour_now = 5'(hour);
    it.minute_now = 6'(minute);
    it.minute_tick = tick;
    it.force_normal = force_n;
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_slot();
    int dur;
    dur = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 6);
    return CFG_DATA_W'($urandom_range(23) * 4096 + $urandom_range(59) * 64 + dur);
  endfunction

  // mostly a walking wall clock and tank temperature around the setpoint,
  // with jumps onto slot start times; the rest is raw noise
  function automatic in_item_t random_tick();
    in_item_t it;
    slot_t s;
    int heater, center;
    if ($urandom_range(99) < 12) begin
      it.tank_temp = 12'($urandom);
      it.heater_temp = 12'($urandom);
      it.hour_now = 5'($urandom);
      it.minute_now = 6'($urandom);
      it.minute_tick = 1'($urandom);
      it.force_normal = 1'($urandom);
      return it;
    end
    it.minute_tick = ($urandom_range(99) < 40);
    if (it.minute_tick) begin
      if (wall_min >= 59) begin
        wall_min = 0;
        wall_hour = (wall_hour >= 23) ? 0 : wall_hour + 1;
      end else begin
        wall_min++;
      end
    end
    if ($urandom_range(99) < 8) begin
      s = sb.slot_cfg[$urandom_range(SLOTS - 1)];
      wall_hour = s[16:12];
      wall_min = s[11:6];
    end
    center = int'(sb.setpoint);
    tank_walk += int'($urandom_range(50)) - 25;
    if (tank_walk < center - 120) tank_walk += 60;
    if (tank_walk > center + 120) tank_walk -= 60;
    if ($urandom_range(99) < 4) tank_walk = int'($urandom_range(1800)) - 550;
    tank_walk = (tank_walk < -550) ? -550 : (tank_walk > 1250) ? 1250 : tank_walk;
    heater = tank_walk + int'($urandom_range(300)) - 100;
    heater = (heater < -550) ? -550 : (heater > 1250) ? 1250 : heater;
    it.tank_temp = 12'(tank_walk);
    it.heater_temp = 12'(heater);
    it.hour_now = 5'(wall_hour);
    it.minute_now = 6'(wall_min);
    it.force_normal = ($urandom_range(99) < 3);
    return it;
  endfunction

  task automatic send_tick(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_W'(it);
    do @(posedge clk); while (!s_tready);
  endtask

  // registers change only once every pending result has come back
  task automatic load_settings();
    @(posedge clk);
    while (sb.due_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_TANK_SETPOINT + CFG_IDX_W'(i);
      cfg_data <= reg_image[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int idle, input int stall, input bit squeeze);
    idle_pct = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      if (squeeze && k == 30) hold_req = 1'b1;
      send_tick(random_tick());
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    in_item_t directed [$];
    int drain;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: setpoint 450, band 410..460, slots 6:00/15, 7:30/5,
    // 12:30/15, 18:00/30
    directed.push_back(ctl_tick(-2048, 2047, 0, 0, 0, 0));   // heat on, pump on
    directed.push_back(ctl_tick(2047, -2048, 31, 63, 1, 1)); // heat off, target 0
    directed.push_back(ctl_tick(-550, 1250, 23, 59, 0, 0));
    directed.push_back(ctl_tick(400, 300, 5, 0, 0, 0));      // heater cold, pump off
    directed.push_back(ctl_tick(300, 500, 7, 30, 0, 0));     // slot hit, tank cold
    directed.push_back(ctl_tick(300, 500, 7, 31, 1, 0));     // still waiting, no count
    directed.push_back(ctl_tick(410, 500, 7, 31, 1, 0));     // warm: pump starts
    directed.push_back(ctl_tick(420, 500, 7, 32, 1, 0));
    directed.push_back(ctl_tick(420, 500, 7, 32, 0, 0));
    directed.push_back(ctl_tick(420, 500, 7, 33, 1, 0));
    directed.push_back(ctl_tick(420, 500, 7, 34, 1, 0));
    directed.push_back(ctl_tick(420, 500, 7, 35, 1, 0));
    directed.push_back(ctl_tick(420, 500, 7, 36, 1, 0));     // run ends
    directed.push_back(ctl_tick(470, 500, 7, 36, 0, 0));
    directed.push_back(ctl_tick(470, 500, 6, 0, 0, 0));
    directed.push_back(ctl_tick(470, 500, 6, 1, 1, 0));
    directed.push_back(ctl_tick(470, 500, 6, 2, 1, 0));
    directed.push_back(ctl_tick(470, 500, 6, 0, 1, 1));      // force, slot rematches
    directed.push_back(ctl_tick(470, 500, 6, 1, 0, 1));      // force drops the start
    directed.push_back(ctl_tick(470, 500, 12, 30, 0, 0));
    directed.push_back(ctl_tick(100, 500, 12, 31, 1, 0));
    directed.push_back(ctl_tick(100, 500, 12, 31, 0, 0));    // still heating, no write
    directed.push_back(ctl_tick(470, 200, 12, 32, 1, 0));
    directed.push_back(ctl_tick(470, 200, 12, 33, 1, 1));
    foreach (directed[i]) send_tick(directed[i]);
    s_tvalid <= 1'b0;

    reg_image = '{17'($urandom_range(350, 550)), 17'($urandom_range(80)),
                  17'($urandom_range(80)), 17'($urandom_range(400)),
                  random_slot(), random_slot(), random_slot(), random_slot()};
    load_settings();
    run_phase(205, 0, 0, 1'b0);

    reg_image = '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd98047, random_slot(), 17'h1FFFF};
    load_settings();
    run_phase(205, 82, 0, 1'b0);

    reg_image = '{17'd1023, 17'd255, 17'd255, 17'd511,
                  random_slot(), random_slot(), random_slot(), random_slot()};
    load_settings();
    run_phase(205, 0, 82, 1'b0);

    reg_image = '{17'd600, 17'd200, 17'd200, 17'd400,
                  random_slot(), random_slot(), random_slot(), random_slot()};
    load_settings();
    run_phase(205, 6, 6, 1'b1);

    reg_image = '{17'($urandom_range(1023)), 17'($urandom_range(255)),
                  17'($urandom_range(255)), 17'($urandom_range(511)),
                  random_slot(), random_slot(), random_slot(), random_slot()};
    load_settings();
    run_phase(205, 0, 0, 1'b0);

    stall_pct = 0;
    drain = 0;
    while (sb.due_outputs.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (6) @(posedge clk);
    if (sb.due_outputs.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.due_outputs.size());
      sb.errors += sb.due_outputs.size();
    end

    $display("run: %0d control ticks sent, %0d results checked, %0d errors",
             sb.n_ticks, sb.n_results, sb.errors);
    $display("run: %0d DAC updates, %0d circulation pump starts, six register settings",
             sb.n_writes, sb.n_runs);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
+incdir+src
src/whcc_pkg.sv
src/whcc_cfg_regs.sv
src/whcc_dac.sv
src/whcc_core.sv
src/water_heater_circulation_controller_unit.sv
sim/testbench.sv
